### rtl/bcfr_pkg.sv
// Types and constants shared by the boot command frame receiver.
package bcfr_pkg;

  typedef enum logic [2:0] {
    EV_DATA      = 3'd0,
    EV_ACCEPT    = 3'd1,
    EV_BADSUM    = 3'd2,
    EV_UNKNOWN   = 3'd3,
    EV_END       = 3'd4,
    EV_TIMEOUT   = 3'd5,
    EV_MALFORMED = 3'd6
  } event_t;

  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LIMIT = 8'd2;

  localparam logic [7:0] START_CODE_RST  = 8'h02;
  localparam logic [7:0] END_CODE_RST    = 8'h17;
  localparam logic [7:0] NOISE_LIMIT_RST = 8'hFF;

  // Command codes of the four known commands
  localparam logic [7:0] CMD_FLASH_ERASE   = 8'h55;
  localparam logic [7:0] CMD_FLASH_PROGRAM = 8'h66;
  localparam logic [7:0] CMD_EE_PROGRAM    = 8'h99;
  localparam logic [7:0] CMD_EE_ERASE      = 8'hAA;

  localparam logic [1:0] CLS_FLASH_ERASE   = 2'd0;
  localparam logic [1:0] CLS_FLASH_PROGRAM = 2'd1;
  localparam logic [1:0] CLS_EE_PROGRAM    = 2'd2;
  localparam logic [1:0] CLS_EE_ERASE      = 2'd3;

  // Frame position codes: 0 hunting, 1 length, 2 command, 3.. data
  localparam logic [7:0] POS_HUNT    = 8'd0;
  localparam logic [7:0] POS_LENGTH  = 8'd1;
  localparam logic [7:0] POS_COMMAND = 8'd2;
  localparam logic [7:0] POS_DATA0   = 8'd3;

  localparam logic [7:0] LEN_MIN     = 8'd2;
  localparam logic [7:0] LEN_BAD     = 8'hFF;

endpackage

### rtl/bcfr_byte_if.sv
// Received byte channel.
interface bcfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

### rtl/bcfr_event_if.sv
// Event channel carrying frame events and payload bytes.
interface bcfr_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] data_byte;
  logic [7:0] data_offset;
  logic [1:0] command_class;

  modport source (output valid, output event_res, output data_byte,
                  output data_offset, output command_class, input ready);
  modport sink   (input valid, input event_res, input data_byte,
                  input data_offset, input command_class, output ready);
endinterface

### rtl/bcfr_cfg_if.sv
// Configuration write channel.
interface bcfr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bcfr_pkg::CFG_IDX_W-1:0]   index;
  logic [7:0]                       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/boot_command_frame_receiver_unit.sv
// Boot command frame receiver: hunts framing bytes, deframes and checks frames.
//
// Channels: rx takes one received byte per word; res gives one event word
// (data byte with offset, frame verdict, end of session, timeout or
// malformed length); cfg writes start_code (index 0), end_code (index 1)
// and noise_limit (index 2), other indexes are ignored. cfg is always ready.
// Path: an accepted byte is held in the input register, its frame state
// update and event are computed there and land in the output register
// when the input register advances.
// Throughput: one byte per cycle while res does not stall, with the
// position, sum and noise counters updated for each accepted byte. Bytes
// that cause no event are absorbed without an output word.
// Reset: frame state and counters clear, framing codes return to 0x02 and
// 0x17, noise limit to 0xFF; no event is pending.
// Stall: while res is not ready and holds a word, the input register holds
// and rx drops ready once that register is full; nothing is lost.
module boot_command_frame_receiver_unit (
  input  logic            clk,
  input  logic            rst,
  bcfr_byte_if.sink       rx,
  bcfr_event_if.source    res,
  bcfr_cfg_if.sink        cfg
);

  logic [7:0] start_code;
  logic [7:0] end_code;
  logic [7:0] noise_limit;

  logic [7:0] position,     position_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_sum,  running_sum_next;
  logic [7:0] noise_count,  noise_count_next;
  logic [7:0] command_byte, command_byte_next;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  logic       emit;
  bcfr_pkg::event_t ev;
  logic [7:0] ev_byte;
  logic [7:0] ev_offset;
  logic [1:0] ev_class;

  logic       out_valid;
  bcfr_pkg::event_t out_event;
  logic [7:0] out_byte;
  logic [7:0] out_offset;
  logic [1:0] out_class;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_code  <= bcfr_pkg::START_CODE_RST;
      end_code    <= bcfr_pkg::END_CODE_RST;
      noise_limit <= bcfr_pkg::NOISE_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        bcfr_pkg::REG_START_CODE:  start_code  <= cfg.data;
        bcfr_pkg::REG_END_CODE:    end_code    <= cfg.data;
        bcfr_pkg::REG_NOISE_LIMIT: noise_limit <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register: move on when the output register is free or being drained
  assign advance  = in_valid && (!out_valid || res.ready);
  assign rx.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_comb begin
    position_next     = position;
    frame_length_next = frame_length;
    running_sum_next  = running_sum;
    noise_count_next  = noise_count;
    command_byte_next = command_byte;
    emit              = 1'b0;
    ev                = bcfr_pkg::EV_DATA;
    ev_byte           = 8'd0;
    ev_offset         = 8'd0;
    ev_class          = bcfr_pkg::CLS_FLASH_ERASE;

    if (position == bcfr_pkg::POS_HUNT) begin
      if (in_byte == start_code) begin
        noise_count_next = 8'd0;
        position_next    = bcfr_pkg::POS_LENGTH;
      end else if (in_byte == end_code) begin
        noise_count_next = 8'd0;
        emit             = 1'b1;
        ev               = bcfr_pkg::EV_END;
      end else if (noise_count < noise_limit) begin
        noise_count_next = noise_count + 8'd1;
      end else begin
        noise_count_next = 8'd0;
        emit             = 1'b1;
        ev               = bcfr_pkg::EV_TIMEOUT;
      end
    end else if (position == bcfr_pkg::POS_LENGTH) begin
      if (in_byte < bcfr_pkg::LEN_MIN || in_byte == bcfr_pkg::LEN_BAD) begin
        position_next = bcfr_pkg::POS_HUNT;
        emit          = 1'b1;
        ev            = bcfr_pkg::EV_MALFORMED;
      end else begin
        frame_length_next = in_byte;
        running_sum_next  = in_byte;
        position_next     = bcfr_pkg::POS_COMMAND;
      end
    end else if (position == bcfr_pkg::POS_COMMAND) begin
      command_byte_next = in_byte;
      running_sum_next  = running_sum + in_byte;
      position_next     = bcfr_pkg::POS_DATA0;
    end else if (position <= frame_length) begin
      running_sum_next = running_sum + in_byte;
      position_next    = position + 8'd1;
      emit             = 1'b1;
      ev               = bcfr_pkg::EV_DATA;
      ev_byte          = in_byte;
      ev_offset        = position - bcfr_pkg::POS_DATA0;
    end else begin
      // Checksum byte: one's complement of the sum closes the frame
      position_next = bcfr_pkg::POS_HUNT;
      emit          = 1'b1;
      if (~running_sum != in_byte) begin
        ev = bcfr_pkg::EV_BADSUM;
      end else begin
        ev = bcfr_pkg::EV_ACCEPT;
        case (command_byte)
          bcfr_pkg::CMD_FLASH_ERASE:   ev_class = bcfr_pkg::CLS_FLASH_ERASE;
          bcfr_pkg::CMD_FLASH_PROGRAM: ev_class = bcfr_pkg::CLS_FLASH_PROGRAM;
          bcfr_pkg::CMD_EE_PROGRAM:    ev_class = bcfr_pkg::CLS_EE_PROGRAM;
          bcfr_pkg::CMD_EE_ERASE:      ev_class = bcfr_pkg::CLS_EE_ERASE;
          default:                     ev       = bcfr_pkg::EV_UNKNOWN;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= bcfr_pkg::POS_HUNT;
      frame_length <= 8'd0;
      running_sum  <= 8'd0;
      noise_count  <= 8'd0;
      command_byte <= 8'd0;
    end else if (advance) begin
      position     <= position_next;
      frame_length <= frame_length_next;
      running_sum  <= running_sum_next;
      noise_count  <= noise_count_next;
      command_byte <= command_byte_next;
    end
  end

  // Output register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_event  <= ev;
      out_byte   <= ev_byte;
      out_offset <= ev_offset;
      out_class  <= ev_class;
    end
  end

  assign res.valid         = out_valid;
  assign res.event_res     = out_event;
  assign res.data_byte     = out_byte;
  assign res.data_offset   = out_offset;
  assign res.command_class = out_class;

endmodule
